/* sv/cabm_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and lexical tables of the C-aware bracket matcher.
// Depends on nothing; every other file of the block imports it.
package cabm_pkg;

   // Width of the nesting counter; the result field depth shows its low 16 bits.
   localparam int DEPTH_BITS  = 16;
   localparam int DEPTH_OUT_W = 16;

   // Decoupling queue between the classifier and the execution stage.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int FWD_STATES  = 9;
   localparam int BWD_STATES  = 8;
   localparam int CLASS_COUNT = 7;

   typedef logic [DEPTH_BITS-1:0] nest_type;
   typedef logic [3:0]            lex_state_type;
   typedef logic [7:0]            char_type;

   typedef enum logic {
      CMD_BEGIN = 1'b0,
      CMD_SCAN  = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      CLS_BSLASH  = 3'd0,
      CLS_SLASH   = 3'd1,
      CLS_QUOTE   = 3'd2,
      CLS_DQUOTE  = 3'd3,
      CLS_STAR    = 3'd4,
      CLS_NEWLINE = 3'd5,
      CLS_OTHER   = 3'd6
   } char_class_type;

   localparam char_type CH_BSLASH  = 8'h5c;
   localparam char_type CH_SLASH   = 8'h2f;
   localparam char_type CH_QUOTE   = 8'h27;
   localparam char_type CH_DQUOTE  = 8'h22;
   localparam char_type CH_STAR    = 8'h2a;
   localparam char_type CH_NEWLINE = 8'h0a;
   localparam char_type CH_LPAREN  = 8'h28;
   localparam char_type CH_RPAREN  = 8'h29;
   localparam char_type CH_LANGLE  = 8'h3c;
   localparam char_type CH_RANGLE  = 8'h3e;
   localparam char_type CH_LSQUARE = 8'h5b;
   localparam char_type CH_RSQUARE = 8'h5d;
   localparam char_type CH_LCURLY  = 8'h7b;
   localparam char_type CH_RCURLY  = 8'h7d;
   localparam char_type CH_LOWER_A = 8'h61;
   localparam char_type CH_LOWER_Z = 8'h7a;
   localparam char_type CASE_DELTA = 8'h20;

   // One classified item as it travels from the front end to the back end.
   typedef struct packed {
      logic           is_begin;
      char_type       chr;
      char_class_type cls;
      char_type       partner;
      logic           backward;
      logic           is_bracket;
   } scan_entry_type;

   // Forward scan: next lexical state by state and character class.
   localparam lex_state_type FWD_NEXT [FWD_STATES][CLASS_COUNT] = '{
      '{4'd0, 4'd1, 4'd4, 4'd6, 4'd0, 4'd0, 4'd0},
      '{4'd0, 4'd8, 4'd4, 4'd6, 4'd2, 4'd0, 4'd0},
      '{4'd2, 4'd2, 4'd2, 4'd2, 4'd3, 4'd2, 4'd2},
      '{4'd2, 4'd0, 4'd2, 4'd2, 4'd3, 4'd2, 4'd2},
      '{4'd5, 4'd4, 4'd0, 4'd4, 4'd4, 4'd0, 4'd4},
      '{4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4},
      '{4'd7, 4'd6, 4'd6, 4'd0, 4'd6, 4'd0, 4'd6},
      '{4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6},
      '{4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd0, 4'd8}
   };
   localparam logic FWD_SKIP [FWD_STATES] = '{
      1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1
   };

   // Backward scan: same classes, states mirrored for reverse order.
   localparam lex_state_type BWD_NEXT [BWD_STATES][CLASS_COUNT] = '{
      '{4'd0, 4'd1, 4'd4, 4'd6, 4'd0, 4'd0, 4'd0},
      '{4'd0, 4'd1, 4'd4, 4'd6, 4'd2, 4'd0, 4'd0},
      '{4'd2, 4'd2, 4'd2, 4'd2, 4'd3, 4'd2, 4'd2},
      '{4'd2, 4'd0, 4'd2, 4'd2, 4'd3, 4'd2, 4'd2},
      '{4'd4, 4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd4},
      '{4'd4, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
      '{4'd6, 4'd6, 4'd6, 4'd7, 4'd6, 4'd7, 4'd6},
      '{4'd6, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0}
   };
   localparam logic BWD_SKIP [BWD_STATES] = '{
      1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0
   };

   function automatic char_class_type classify(char_type c);
      char_class_type cls;
      case (c)
         CH_BSLASH:  cls = CLS_BSLASH;
         CH_SLASH:   cls = CLS_SLASH;
         CH_QUOTE:   cls = CLS_QUOTE;
         CH_DQUOTE:  cls = CLS_DQUOTE;
         CH_STAR:    cls = CLS_STAR;
         CH_NEWLINE: cls = CLS_NEWLINE;
         default:    cls = CLS_OTHER;
      endcase
      return cls;
   endfunction

   function automatic char_type fold(char_type c, logic enable);
      char_type r;
      r = c;
      if (enable && c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
         r = c - CASE_DELTA;
      end
      return r;
   endfunction

   function automatic logic [DEPTH_OUT_W-1:0] depth_field(nest_type n);
      logic [31:0] wide;
      wide = 32'(n);
      return wide[DEPTH_OUT_W-1:0];
   endfunction

endpackage

/* sv/cabm_ifs.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the bracket matcher: request, response
// and register write. Uses the types of cabm_pkg.
interface cabm_req_if import cabm_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     cmd;
   char_type char_in;

   modport source (output valid, cmd, char_in, input ready);
   modport sink   (input valid, cmd, char_in, output ready);
endinterface

interface cabm_rsp_if import cabm_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   found;
   logic                   skipped;
   logic [DEPTH_OUT_W-1:0] depth;
   logic                   backward;
   logic                   is_bracket;

   modport source (output valid, found, skipped, depth, backward, is_bracket,
                   input ready);
   modport sink   (input valid, found, skipped, depth, backward, is_bracket,
                   output ready);
endinterface

interface cabm_csr_if ();
   logic valid;
   logic ready;
   logic case_fold;

   modport source (output valid, case_fold, input ready);
   modport sink   (input valid, case_fold, output ready);
endinterface

/* sv/cabm_front.sv */
`timescale 1ns / 1ps
// Front end: accepts request transfers and classifies each character.
// Uses cabm_pkg and the request interface.
module cabm_front import cabm_pkg::*; (
   cabm_req_if.sink        req_bus,
   input  logic            q_full,
   output logic            push,
   output scan_entry_type  push_entry
);

   char_type partner;
   logic     backward;
   logic     is_bracket;

   // Bracket decode: openers search forward for their closer, closers search
   // backward for their opener, anything else looks for itself.
   always_comb begin
      partner    = req_bus.char_in;
      backward   = 1'b0;
      is_bracket = 1'b1;
      unique case (req_bus.char_in)
         CH_LPAREN:  partner = CH_RPAREN;
         CH_LANGLE:  partner = CH_RANGLE;
         CH_LSQUARE: partner = CH_RSQUARE;
         CH_LCURLY:  partner = CH_RCURLY;
         CH_RPAREN: begin
            partner  = CH_LPAREN;
            backward = 1'b1;
         end
         CH_RANGLE: begin
            partner  = CH_LANGLE;
            backward = 1'b1;
         end
         CH_RSQUARE: begin
            partner  = CH_LSQUARE;
            backward = 1'b1;
         end
         CH_RCURLY: begin
            partner  = CH_LCURLY;
            backward = 1'b1;
         end
         default: is_bracket = 1'b0;
      endcase
   end

   assign req_bus.ready = !q_full;
   assign push          = req_bus.valid && !q_full;

   always_comb begin
      push_entry.is_begin   = (req_bus.cmd == CMD_BEGIN);
      push_entry.chr        = req_bus.char_in;
      push_entry.cls        = classify(req_bus.char_in);
      push_entry.partner    = partner;
      push_entry.backward   = backward;
      push_entry.is_bracket = is_bracket;
   end

endmodule

/* sv/cabm_queue.sv */
`timescale 1ns / 1ps
// Short FIFO that decouples the front end from the back end.
// Uses the entry type and depth constants of cabm_pkg.
module cabm_queue import cabm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  scan_entry_type push_entry,
   output logic           full,
   input  logic           pop,
   output logic           not_empty,
   output scan_entry_type pop_entry
);

   scan_entry_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]       count_ff, count_in;

   localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(QUEUE_DEPTH);

   assign full      = (count_ff == FULL_CNT);
   assign not_empty = (count_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* sv/cabm_back.sv */
`timescale 1ns / 1ps
// Back end: lexical state machine, nesting counter and the response register.
// Uses cabm_pkg and the response interface.
module cabm_back import cabm_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            case_fold,
   input  logic            q_not_empty,
   input  scan_entry_type  q_entry,
   output logic            pop,
   cabm_rsp_if.source      rsp_bus
);

   localparam nest_type NEST_MAX = '1;

   lex_state_type lex_ff, lex_in;
   nest_type      nest_ff, nest_in;
   char_type      start_ff, start_in;
   char_type      partner_ff, partner_in;
   logic          backward_ff, backward_in;
   logic          bracket_ff, bracket_in;
   logic          done_ff, done_in;

   logic                   rsp_valid_ff;
   logic                   found_ff, found_in;
   logic                   skipped_ff, skipped_in;
   logic [DEPTH_OUT_W-1:0] depth_ff, depth_in;
   logic                   rsp_back_ff;
   logic                   rsp_brk_ff;

   lex_state_type st;
   logic          skip;
   lex_state_type st_next;
   logic          is_partner;
   logic          is_start;

   assign pop = q_not_empty && (!rsp_valid_ff || rsp_bus.ready);

   // Table lookup for the latched direction; states outside a table count as
   // normal code.
   always_comb begin
      st = lex_ff;
      if (backward_ff) begin
         if (st >= 4'(BWD_STATES)) begin
            st = '0;
         end
         skip    = BWD_SKIP[st[2:0]];
         st_next = BWD_NEXT[st[2:0]][q_entry.cls];
      end else begin
         if (st >= 4'(FWD_STATES)) begin
            st = '0;
         end
         skip    = FWD_SKIP[st];
         st_next = FWD_NEXT[st][q_entry.cls];
      end
      is_partner = (fold(q_entry.chr, case_fold) == fold(partner_ff, case_fold));
      is_start   = (fold(q_entry.chr, case_fold) == fold(start_ff, case_fold));
   end

   always_comb begin
      lex_in      = lex_ff;
      nest_in     = nest_ff;
      start_in    = start_ff;
      partner_in  = partner_ff;
      backward_in = backward_ff;
      bracket_in  = bracket_ff;
      done_in     = done_ff;
      found_in    = 1'b0;
      skipped_in  = 1'b0;
      if (q_entry.is_begin) begin
         start_in    = q_entry.chr;
         partner_in  = q_entry.partner;
         backward_in = q_entry.backward;
         bracket_in  = q_entry.is_bracket;
         nest_in     = '0;
         lex_in      = '0;
         done_in     = 1'b0;
      end else if (!done_ff) begin
         lex_in     = st_next;
         skipped_in = skip;
         if (!skip) begin
            if (is_partner) begin
               if (nest_ff == '0) begin
                  found_in = 1'b1;
                  done_in  = 1'b1;
               end else begin
                  nest_in = nest_ff - 1'b1;
               end
            end else if (is_start && nest_ff != NEST_MAX) begin
               nest_in = nest_ff + 1'b1;
            end
         end
      end
      depth_in = depth_field(nest_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lex_ff       <= '0;
         nest_ff      <= '0;
         start_ff     <= '0;
         partner_ff   <= '0;
         backward_ff  <= 1'b0;
         bracket_ff   <= 1'b0;
         done_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            lex_ff      <= lex_in;
            nest_ff     <= nest_in;
            start_ff    <= start_in;
            partner_ff  <= partner_in;
            backward_ff <= backward_in;
            bracket_ff  <= bracket_in;
            done_ff     <= done_in;
         end
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         found_ff    <= found_in;
         skipped_ff  <= skipped_in;
         depth_ff    <= depth_in;
         rsp_back_ff <= backward_in;
         rsp_brk_ff  <= bracket_in;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.found      = found_ff;
   assign rsp_bus.skipped    = skipped_ff;
   assign rsp_bus.depth      = depth_ff;
   assign rsp_bus.backward   = rsp_back_ff;
   assign rsp_bus.is_bracket = rsp_brk_ff;

endmodule

/* sv/c_aware_bracket_matcher_core.sv */
`timescale 1ns / 1ps
// Top level of the C-aware bracket matcher: front end, queue, back end and
// the case-fold register. Uses cabm_pkg, cabm_ifs, cabm_front, cabm_queue, cabm_back.

// A begin transfer (cmd 0) latches the start character and the direction of
// the search; each scan transfer (cmd 1) then carries one character in search
// order, and every request transfer yields exactly one response transfer.
// Characters inside block comments, character quotes and strings, and in a
// forward scan also inside line comments, are reported as skipped and never
// count. While the response side is ready, the block sustains one transfer
// per clock cycle: the front end classifies a character in the cycle it
// arrives and writes it into a two-entry queue, and the back end updates the
// lexical state and nesting count for one entry per cycle into the response
// register. The queue absorbs a stall on the response side, so requests keep
// flowing until both queue entries are occupied. Write case_fold only while
// no response is outstanding; the register port is always ready.

module c_aware_bracket_matcher_core import cabm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   cabm_req_if.sink   req_bus,
   cabm_rsp_if.source rsp_bus,
   cabm_csr_if.sink   csr_bus
);

   logic           case_fold_ff;
   logic           push;
   scan_entry_type push_entry;
   logic           q_full;
   logic           pop;
   logic           q_not_empty;
   scan_entry_type q_entry;

   // Case-fold control: written by the register port, read by the back end
   // on every comparison against the start and partner characters.
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         case_fold_ff <= 1'b0;
      end else if (csr_bus.valid) begin
         case_fold_ff <= csr_bus.case_fold;
      end
   end

   cabm_front u_front (
      .req_bus    (req_bus),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   cabm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .not_empty  (q_not_empty),
      .pop_entry  (q_entry)
   );

   cabm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .case_fold   (case_fold_ff),
      .q_not_empty (q_not_empty),
      .q_entry     (q_entry),
      .pop         (pop),
      .rsp_bus     (rsp_bus)
   );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench of c_aware_bracket_matcher_core, with its own model
// of the lexer, nesting count and case folding. Depends on cabm_pkg, cabm_ifs and c_aware_bracket_matcher_core.
module tb_top;
   import cabm_pkg::*;

   localparam int CLK_HALF   = 6;
   localparam int WDOG_LIMIT = 2000;
   localparam int TAIL_WAIT  = 8;
   localparam int NEST_LEVELS = 40;

   // One response of the block, field for field.
   typedef struct packed {
      logic                   found;
      logic                   skipped;
      logic [DEPTH_OUT_W-1:0] depth;
      logic                   backward;
      logic                   is_bracket;
   } match_result_type;

   // The lexical state machines of both scan directions. Rows are lexical
   // states, columns are character classes in the order of char_class_type.
   localparam lex_state_type FWD_LEX_NEXT [FWD_STATES][CLASS_COUNT] = '{
      '{4'd0, 4'd1, 4'd4, 4'd6, 4'd0, 4'd0, 4'd0},
      '{4'd0, 4'd8, 4'd4, 4'd6, 4'd2, 4'd0, 4'd0},
      '{4'd2, 4'd2, 4'd2, 4'd2, 4'd3, 4'd2, 4'd2},
      '{4'd2, 4'd0, 4'd2, 4'd2, 4'd3, 4'd2, 4'd2},
      '{4'd5, 4'd4, 4'd0, 4'd4, 4'd4, 4'd0, 4'd4},
      '{4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4},
      '{4'd7, 4'd6, 4'd6, 4'd0, 4'd6, 4'd0, 4'd6},
      '{4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6},
      '{4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd0, 4'd8}
   };
   localparam logic FWD_LEX_SKIP [FWD_STATES] = '{
      1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1
   };
   localparam lex_state_type BWD_LEX_NEXT [BWD_STATES][CLASS_COUNT] = '{
      '{4'd0, 4'd1, 4'd4, 4'd6, 4'd0, 4'd0, 4'd0},
      '{4'd0, 4'd1, 4'd4, 4'd6, 4'd2, 4'd0, 4'd0},
      '{4'd2, 4'd2, 4'd2, 4'd2, 4'd3, 4'd2, 4'd2},
      '{4'd2, 4'd0, 4'd2, 4'd2, 4'd3, 4'd2, 4'd2},
      '{4'd4, 4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd4},
      '{4'd4, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
      '{4'd6, 4'd6, 4'd6, 4'd7, 4'd6, 4'd7, 4'd6},
      '{4'd6, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0}
   };
   localparam logic BWD_LEX_SKIP [BWD_STATES] = '{
      1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0
   };

   localparam char_type OPENERS [4] = '{CH_LPAREN, CH_LANGLE, CH_LSQUARE, CH_LCURLY};
   localparam char_type CLOSERS [4] = '{CH_RPAREN, CH_RANGLE, CH_RSQUARE, CH_RCURLY};

   logic clock = 1'b0;
   logic reset = 1'b1;

   cabm_req_if req_if ();
   cabm_rsp_if rsp_if ();
   cabm_csr_if csr_if ();

   c_aware_bracket_matcher_core i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   always #(CLK_HALF) clock = ~clock;

   // Shadow copy of the matcher state, advanced once per accepted request.
   logic          fold_q;
   lex_state_type lex_q;
   nest_type      nest_q;
   char_type      start_q;
   char_type      partner_q;
   logic          back_q;
   logic          done_q;

   match_result_type expected_matches[$];

   int sender_idle_pct = 0;
   int recv_stall_pct  = 0;
   int fail_count      = 0;
   int live_count      = 0;
   int idle_cycles     = 0;

   // ------------------------------------------------------------------------
   // Model of the block.
   // ------------------------------------------------------------------------

   function automatic char_class_type char_kind(char_type c);
      case (c)
         CH_BSLASH:  return CLS_BSLASH;
         CH_SLASH:   return CLS_SLASH;
         CH_QUOTE:   return CLS_QUOTE;
         CH_DQUOTE:  return CLS_DQUOTE;
         CH_STAR:    return CLS_STAR;
         CH_NEWLINE: return CLS_NEWLINE;
         default:    return CLS_OTHER;
      endcase
   endfunction

   // Folding only ever maps lower case onto upper case, and only when enabled.
   function automatic char_type upcase(char_type c);
      if (fold_q && c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
         return c - CASE_DELTA;
      end
      return c;
   endfunction

   function automatic logic is_bracket_char(char_type c);
      int i;
      for (i = 0; i < 4; i++) begin
         if (OPENERS[i] == c || CLOSERS[i] == c) begin
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // Advances the shadow state by one request and returns the response that
   // the block owes for it. A scan while no search is open leaves the state
   // as it is.
   function automatic match_result_type step_matcher(cmd_type cmd, char_type c);
      match_result_type r;
      char_class_type   kind;
      lex_state_type    st;
      logic             skip;
      int               i;
      r    = '0;
      skip = 1'b0;
      if (cmd == CMD_BEGIN) begin
         start_q   = c;
         partner_q = c;
         back_q    = 1'b0;
         for (i = 0; i < 4; i++) begin
            if (OPENERS[i] == c) begin
               partner_q = CLOSERS[i];
            end
            if (CLOSERS[i] == c) begin
               partner_q = OPENERS[i];
               back_q    = 1'b1;
            end
         end
         nest_q = '0;
         lex_q  = '0;
         done_q = 1'b0;
      end else if (!done_q) begin
         kind = char_kind(c);
         st   = lex_q;
         if (back_q) begin
            if (st >= BWD_STATES) st = '0;
            skip  = BWD_LEX_SKIP[st];
            lex_q = BWD_LEX_NEXT[st][kind];
         end else begin
            if (st >= FWD_STATES) st = '0;
            skip  = FWD_LEX_SKIP[st];
            lex_q = FWD_LEX_NEXT[st][kind];
         end
         if (!skip) begin
            if (upcase(c) == upcase(partner_q)) begin
               if (nest_q == '0) begin
                  r.found = 1'b1;
                  done_q  = 1'b1;
               end else begin
                  nest_q = nest_q - 1'b1;
               end
            end else if (upcase(c) == upcase(start_q)) begin
               // The count sticks at all ones instead of wrapping.
               if (nest_q != '1) begin
                  nest_q = nest_q + 1'b1;
               end
            end
         end
      end
      r.skipped    = skip;
      r.depth      = DEPTH_OUT_W'(nest_q);
      r.backward   = back_q;
      r.is_bracket = is_bracket_char(start_q);
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Drivers. Every input is driven with a nonblocking assignment at the
   // rising edge, and handshakes are sampled at the edge, so the block and
   // the testbench see the same values regardless of process order.
   // ------------------------------------------------------------------------

   // Sends one request. On return the transfer has just happened and valid
   // is still high: the caller either sends again at once, so valid stays
   // up, or calls a task that lowers it in this same time step.
   task automatic send_item(cmd_type cmd, char_type c);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.cmd     <= cmd;
      req_if.char_in <= c;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      live_count++;
      expected_matches.push_back(step_matcher(cmd, c));
   endtask

   task automatic scan_text(string s);
      int i;
      for (i = 0; i < s.len(); i++) begin
         send_item(CMD_SCAN, char_type'(s[i]));
      end
   endtask

   // Holds the request side idle until every owed response has come back.
   // Each request yields exactly one response, so an empty store means the
   // block has nothing left in flight.
   task automatic wait_drain();
      req_if.valid <= 1'b0;
      while (expected_matches.size() != 0) @(posedge clock);
   endtask

   task automatic write_case_fold(logic value);
      wait_drain();
      csr_if.valid     <= 1'b1;
      csr_if.case_fold <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      fold_q = value;
      csr_if.valid <= 1'b0;
   endtask

   // The response side stalls at random at the rate of the current phase.
   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // ------------------------------------------------------------------------
   // Response checker: every response transfer is matched against the oldest
   // outstanding prediction.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      match_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_matches.size() == 0) begin
            $error("response transfer with no request outstanding");
            fail_count++;
         end else begin
            want = expected_matches.pop_front();
            if (rsp_if.found !== want.found) begin
               $error("found: expected %0d, actual %0d", want.found, rsp_if.found);
               fail_count++;
            end
            if (rsp_if.skipped !== want.skipped) begin
               $error("skipped: expected %0d, actual %0d", want.skipped, rsp_if.skipped);
               fail_count++;
            end
            if (rsp_if.depth !== want.depth) begin
               $error("depth: expected %0d, actual %0d", want.depth, rsp_if.depth);
               fail_count++;
            end
            if (rsp_if.backward !== want.backward) begin
               $error("backward: expected %0d, actual %0d",
                      want.backward, rsp_if.backward);
               fail_count++;
            end
            if (rsp_if.is_bracket !== want.is_bracket) begin
               $error("is_bracket: expected %0d, actual %0d",
                      want.is_bracket, rsp_if.is_bracket);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: a run of cycles without any transfer on any channel means the
   // block has hung.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_if.valid && csr_if.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WDOG_LIMIT) begin
            $error("no transfer for %0d cycles", WDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Random character sources.
   // ------------------------------------------------------------------------

   function automatic char_type lexical_char();
      case ($urandom_range(5))
         0:       return CH_SLASH;
         1:       return CH_STAR;
         2:       return CH_QUOTE;
         3:       return CH_DQUOTE;
         4:       return CH_BSLASH;
         default: return CH_NEWLINE;
      endcase
   endfunction

   function automatic char_type any_bracket();
      if ($urandom_range(1)) return OPENERS[$urandom_range(3)];
      return CLOSERS[$urandom_range(3)];
   endfunction

   function automatic char_type pick_start();
      int k;
      k = $urandom_range(99);
      if (k < 50) return any_bracket();
      if (k < 70) begin
         return char_type'($urandom_range(8'h41, 8'h5a) | ($urandom_range(1) << 5));
      end
      if (k < 80) return lexical_char();
      return char_type'($urandom_range(255));
   endfunction

   // Scan characters lean toward what drives the search: the partner, the
   // start character, their other case, and the lexer's special characters.
   function automatic char_type pick_scan_char();
      int k;
      k = $urandom_range(99);
      if (k < 20) return partner_q;
      if (k < 35) return start_q;
      if (k < 45) return ($urandom_range(1) ? start_q : partner_q) ^ CASE_DELTA;
      if (k < 70) return lexical_char();
      if (k < 80) return any_bracket();
      return char_type'($urandom_range(255));
   endfunction

   // ------------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------------

   // Nesting, found, the idle state and the byte extremes.
   task automatic test_directed();
      // A scan straight after reset finds no open search and is ignored.
      send_item(CMD_SCAN, CH_LOWER_A);
      send_item(CMD_BEGIN, CH_LPAREN);
      scan_text("(x))");
      // The search is closed, so this one is ignored too.
      send_item(CMD_SCAN, CH_RPAREN);
      // A closing bracket searches backward for its opener.
      send_item(CMD_BEGIN, CH_RSQUARE);
      scan_text("][[");
      send_item(CMD_BEGIN, 8'h00);
      send_item(CMD_SCAN, 8'hff);
      send_item(CMD_SCAN, 8'h00);
      send_item(CMD_BEGIN, 8'hff);
      send_item(CMD_SCAN, 8'hff);
   endtask

   // Brackets inside comments, strings, quotes and escapes are skipped.
   task automatic test_lexer();
      send_item(CMD_BEGIN, CH_LCURLY);
      scan_text("/*}*/\"\\\"}\"'}'//}\n}");
      send_item(CMD_BEGIN, CH_RPAREN);
      scan_text("/*(*/\"(\"'('\n(");
      wait_drain();
   endtask

   task automatic test_case_fold();
      write_case_fold(1'b1);
      send_item(CMD_BEGIN, "q");
      scan_text("Q");
      send_item(CMD_BEGIN, "Z");
      scan_text("{z");
      write_case_fold(1'b0);
      send_item(CMD_BEGIN, "q");
      scan_text("Qq");
      wait_drain();
   endtask

   // Nests many levels deep back to back, then walks the count down again
   // until the closer at depth zero is found.
   task automatic test_deep_nesting();
      sender_idle_pct = 0;
      recv_stall_pct  = 0;
      send_item(CMD_BEGIN, CH_LPAREN);
      repeat (NEST_LEVELS) send_item(CMD_SCAN, CH_LPAREN);
      repeat (NEST_LEVELS + 1) send_item(CMD_SCAN, CH_RPAREN);
      wait_drain();
   endtask

   // Mostly whole searches with random content; one in ten picks are bursts
   // of unrelated requests. Halfway through, the sender stops until every
   // response is back.
   task automatic test_random(int send_pct, int stall_pct, logic fold, int quota);
      int target;
      int n;
      bit paused;
      write_case_fold(fold);
      sender_idle_pct = send_pct;
      recv_stall_pct  = stall_pct;
      target = live_count + quota;
      paused = 1'b0;
      while (live_count < target) begin
         if (!paused && live_count >= target - quota / 2) begin
            wait_drain();
            paused = 1'b1;
         end
         if ($urandom_range(99) < 10) begin
            repeat ($urandom_range(1, 5)) begin
               send_item(cmd_type'($urandom_range(1)), char_type'($urandom_range(255)));
            end
         end else begin
            send_item(CMD_BEGIN, pick_start());
            n = $urandom_range(1, 24);
            repeat (n) send_item(CMD_SCAN, pick_scan_char());
         end
      end
      wait_drain();
   endtask

   initial begin
      req_if.valid     = 1'b0;
      req_if.cmd       = CMD_BEGIN;
      req_if.char_in   = '0;
      rsp_if.ready     = 1'b0;
      csr_if.valid     = 1'b0;
      csr_if.case_fold = 1'b0;
      fold_q    = 1'b0;
      lex_q     = '0;
      nest_q    = '0;
      start_q   = '0;
      partner_q = '0;
      back_q    = 1'b0;
      done_q    = 1'b1;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_lexer();
      test_case_fold();
      test_deep_nesting();
      test_random(0, 0, 1'b0, 150);
      test_random(70, 0, 1'b1, 150);
      test_random(0, 70, 1'b0, 150);
      test_random(24, 24, 1'b1, 150);

      wait_drain();
      recv_stall_pct = 0;
      repeat (TAIL_WAIT) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
